// ----- design/ssf_pkg.sv -----
// ----------------------------------------------------------------------------
// ssf_pkg
// shared types and constants of the subnet source filter
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int unsigned Entries = 256;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_ALL    = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_BIND   = 2'd2,
    MODE_ANY    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_IFACE = 2'd1,
    REG_NAMED = 2'd2
  } reg_e;

  // classified request passed from the front to the back
  typedef struct packed {
    cmd_e         cmd;
    logic         v6;
    logic [63:0]  addr_hi;
    logic [63:0]  addr_lo;
    logic [63:0]  mask_hi;
    logic [63:0]  mask_lo;
    logic         ptp;
    logic [63:0]  peer_hi;
    logic [63:0]  peer_lo;
    logic [7:0]   iface;
    logic         decided;  // verdict known without a table scan
    logic         verdict;
    logic         restricted;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_TEST = 2'd2,
    ST_DONE = 2'd3
  } state_e;

endpackage

// ----- design/ssf_front.sv -----
// ----------------------------------------------------------------------------
// ssf_front
// accepts requests, masks addresses to family width and settles quick verdicts
// ----------------------------------------------------------------------------
module ssf_front import ssf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic        is_v6_i,
  input  logic [63:0] addr_hi_i,
  input  logic [63:0] addr_lo_i,
  input  logic [63:0] mask_hi_i,
  input  logic [63:0] mask_lo_i,
  input  logic        is_ptp_i,
  input  logic [63:0] dst_hi_i,
  input  logic [63:0] dst_lo_i,
  input  logic [7:0]  iface_id_i,
  input  mode_e       mode_i,
  input  logic        named_i,
  output req_t        req_o,
  output logic        req_valid_o,
  input  logic        req_ready_i
);

  localparam int unsigned Depth = 2;

  req_t             fifo_q [Depth];
  logic [0:0]       wr_q, rd_q;
  logic [1:0]       cnt_q;
  req_t             r;
  logic             v6, restr;
  logic [63:0]      ahi, alo;
  logic             do_push, do_pop;

  always_comb begin
    r       = '0;
    r.cmd   = cmd_e'(cmd_i);
    v6      = is_v6_i;
    ahi     = v6 ? addr_hi_i : 64'd0;
    alo     = v6 ? addr_lo_i : {32'd0, addr_lo_i[31:0]};
    restr   = (mode_i == MODE_SINGLE || mode_i == MODE_BIND) && named_i;
    r.ptp   = is_ptp_i;
    r.iface = iface_id_i;
    r.mask_hi = v6 ? mask_hi_i : 64'd0;
    r.mask_lo = v6 ? mask_lo_i : {32'd0, mask_lo_i[31:0]};
    r.peer_hi = v6 ? dst_hi_i : 64'd0;
    r.peer_lo = v6 ? dst_lo_i : {32'd0, dst_lo_i[31:0]};
    if (r.cmd == CMD_CHECK) begin
      // fold mapped v4
      if (v6 && ahi == 64'd0 && alo[63:32] == 32'h0000_ffff) begin
        v6  = 1'b0;
        alo = {32'd0, alo[31:0]};
      end
      if (mode_i == MODE_ALL) begin
        r.decided = 1'b1;
        r.verdict = 1'b1;
      end else if (!v6 && alo[31:24] == 8'h7f) begin
        r.decided = 1'b1;
        r.verdict = 1'b1;
      end else if (v6 && ahi == 64'd0 && alo == 64'd1) begin
        r.decided = 1'b1;
        r.verdict = 1'b1;
      end else if (v6 && restr && ahi[63:56] == 8'hfe && ahi[55:54] == 2'b10) begin
        r.decided = 1'b1;
        r.verdict = 1'b0;
      end
    end else begin
      r.decided = 1'b1;
    end
    r.v6         = v6;
    r.addr_hi    = ahi;
    r.addr_lo    = alo;
    r.restricted = restr;
  end

  assign full        = (cnt_q == 2'(Depth));
  assign do_push     = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign do_pop      = req_valid_o && req_ready_i;
  assign req_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_q] <= r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- design/ssf_back.sv -----
// ----------------------------------------------------------------------------
// ssf_back
// table store and sequential scan, each entry read and then tested; no new request is taken while a scan runs
// ----------------------------------------------------------------------------
module ssf_back import ssf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       req_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [7:0] bound_i,
  output logic       res_valid_o,
  output logic       allowed_o,
  output logic       dropped_o,
  input  logic       res_ready_i
);

  logic [63:0] ah_m [Entries];
  logic [63:0] al_m [Entries];
  logic [63:0] mh_m [Entries];
  logic [63:0] ml_m [Entries];
  logic [63:0] ph_m [Entries];
  logic [63:0] pl_m [Entries];
  logic [10:0] fl_m [Entries];

  logic [63:0] ah_q, al_q, mh_q, ml_q, ph_q, pl_q;
  logic [10:0] fl_q;
  state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, k_q, k_d;
  req_t        cur_q, cur_d;
  logic        out_v_q, out_v_d, al_q2, al_d, dr_q, dr_d;
  logic        rd_en, wr_en, hit;

  assign res_valid_o = out_v_q;
  assign allowed_o   = al_q2;
  assign dropped_o   = dr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ah_m[cnt_q[IdxW-1:0]] <= req_i.addr_hi;
      al_m[cnt_q[IdxW-1:0]] <= req_i.addr_lo;
      mh_m[cnt_q[IdxW-1:0]] <= req_i.mask_hi;
      ml_m[cnt_q[IdxW-1:0]] <= req_i.mask_lo;
      ph_m[cnt_q[IdxW-1:0]] <= req_i.peer_hi;
      pl_m[cnt_q[IdxW-1:0]] <= req_i.peer_lo;
      fl_m[cnt_q[IdxW-1:0]] <= {req_i.iface, req_i.ptp,
                                ((req_i.mask_hi | req_i.mask_lo) != 64'd0), req_i.v6};
    end
    if (rd_en) begin
      ah_q <= ah_m[k_q[IdxW-1:0]];
      al_q <= al_m[k_q[IdxW-1:0]];
      mh_q <= mh_m[k_q[IdxW-1:0]];
      ml_q <= ml_m[k_q[IdxW-1:0]];
      ph_q <= ph_m[k_q[IdxW-1:0]];
      pl_q <= pl_m[k_q[IdxW-1:0]];
      fl_q <= fl_m[k_q[IdxW-1:0]];
    end
  end

  always_comb begin
    hit = 1'b0;
    if (!(cur_q.restricted && fl_q[10:3] != bound_i) && fl_q[0] == cur_q.v6) begin
      if (fl_q[2] && ph_q == cur_q.addr_hi && pl_q == cur_q.addr_lo) hit = 1'b1;
      if (fl_q[1] && (ah_q & mh_q) == (cur_q.addr_hi & mh_q)
          && (al_q & ml_q) == (cur_q.addr_lo & ml_q)) hit = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    cur_d       = cur_q;
    out_v_d     = out_v_q && !res_ready_i;
    al_d        = al_q2;
    dr_d        = dr_q;
    req_ready_o = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i && !out_v_d) begin
          req_ready_o = 1'b1;
          cur_d       = req_i;
          k_d         = '0;
          if (req_i.cmd == CMD_CHECK && !req_i.decided) begin
            state_d = ST_READ;
          end else begin
            out_v_d = 1'b1;
            al_d    = req_i.verdict;
            dr_d    = 1'b0;
            case (req_i.cmd)
              CMD_CLEAR: cnt_d = '0;
              CMD_APPEND: begin
                if (cnt_q == CntW'(Entries)) begin
                  dr_d = 1'b1;
                end else begin
                  wr_en = 1'b1;
                  cnt_d = cnt_q + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_READ: begin
        if (k_q == cnt_q) begin
          al_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (hit) begin
          al_d    = 1'b1;
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_v_d) begin
          out_v_d = 1'b1;
          dr_d    = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    k_q   <= k_d;
    al_q2 <= al_d;
    dr_q  <= dr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

endmodule

// ----- design/subnet_source_filter.sv -----
// ----------------------------------------------------------------------------
// subnet_source_filter
// source-address filter for inbound connections with an interface table
// ----------------------------------------------------------------------------
// a clear, an append or a quickly decided check passes the front queue and the
// back result register before it can be popped; a table check also walks the
// stored entries in turn and stops at the first one that matches
// throughput: one request per cycle while no scan runs and results are popped;
// a scan holds the back part, each entry is read from the table and tested next
// reset empties the table and all queues; config registers reset to zero
module subnet_source_filter import ssf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic        is_v6_i,
  input  logic [63:0] addr_hi_i,
  input  logic [63:0] addr_lo_i,
  input  logic [63:0] mask_hi_i,
  input  logic [63:0] mask_lo_i,
  input  logic        is_ptp_i,
  input  logic [63:0] dst_hi_i,
  input  logic [63:0] dst_lo_i,
  input  logic [7:0]  iface_id_i,
  output logic        empty,
  input  logic        pop,
  output logic        allowed_o,
  output logic        entry_dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  mode_e      mode_q;
  logic [7:0] bound_q;
  logic       named_q;
  req_t       req;
  logic       req_valid, req_ready, res_valid;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ALL;
      bound_q <= '0;
      named_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_MODE:  mode_q  <= mode_e'(cfg_data_i[1:0]);
        REG_IFACE: bound_q <= cfg_data_i;
        REG_NAMED: named_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front: classification and request queue
  ssf_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .cmd_i, .is_v6_i, .addr_hi_i, .addr_lo_i, .mask_hi_i, .mask_lo_i,
    .is_ptp_i, .dst_hi_i, .dst_lo_i, .iface_id_i,
    .mode_i      (mode_q),
    .named_i     (named_q),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready)
  );

  // back: table and scan, result register towards the consumer
  ssf_back u_back (
    .clk_i, .rst_ni,
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .bound_i     (bound_q),
    .res_valid_o (res_valid),
    .allowed_o   (allowed_o),
    .dropped_o   (entry_dropped_o),
    .res_ready_i (pop)
  );

  assign empty = !res_valid;

endmodule
